// ===== hdl/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
// No dependencies; imported by every module of the block except gbs_ram.
package gbs_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam int IDX_W = 6;
	localparam int COORD_W = 16;
	localparam int SCORE_W = 16;
	localparam int AREA_W = 33;
	localparam int BOX_W = 4 * COORD_W;
	localparam logic [15:0] IOU_LIMIT_RST = 16'd29491;

	typedef struct packed {
		logic signed [COORD_W-1:0] left_x;
		logic signed [COORD_W-1:0] top_y;
		logic signed [COORD_W-1:0] right_x;
		logic signed [COORD_W-1:0] bottom_y;
		logic [SCORE_W-1:0] score;
		logic final_box;
	} box_t;

	typedef struct packed {
		logic [IDX_W-1:0] kept_index;
		logic last_kept;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic sel_issue;
		logic cmp_issue;
		logic fetch;
		logic pivot_latch;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pipe_empty;
		logic found;
	} status_t;

endpackage

// ===== hdl/gbs_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module gbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/gbs_ctrl.sv =====
// Sequencer for load, max-score selection, pairwise overlap scan and emission.
// Uses gbs_pkg command and status types; drives gbs_dp.
module gbs_ctrl
	import gbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    final_box,
	input  status_t stat,
	output logic    busy,
	output cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SELI = 3'd1;
	localparam logic [2:0] S_SEL  = 3'd2;
	localparam logic [2:0] S_SELW = 3'd3;
	localparam logic [2:0] S_DEC  = 3'd4;
	localparam logic [2:0] S_FETW = 3'd5;
	localparam logic [2:0] S_CMP  = 3'd6;
	localparam logic [2:0] S_DRN  = 3'd7;

	logic [2:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (final_box) state_d = S_SELI;
				end
			end
			S_SELI: begin
				cmd.scan_clr = 1'b1;
				state_d = S_SEL;
			end
			S_SEL: begin
				cmd.sel_issue = 1'b1;
				if (stat.scan_last) state_d = S_SELW;
			end
			S_SELW: state_d = S_DEC;
			S_DEC: begin
				if (stat.found) begin
					cmd.fetch = 1'b1;
					state_d = S_FETW;
				end else begin
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FETW: begin
				cmd.pivot_latch = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp_issue = 1'b1;
				if (stat.scan_last) state_d = S_DRN;
			end
			S_DRN: begin
				if (stat.pipe_empty) state_d = S_SELI;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/gbs_dp.sv =====
// Datapath: box, area and score RAMs, scan counter, selection and IoU pipeline.
// Uses gbs_pkg and gbs_ram; commanded by gbs_ctrl.
module gbs_dp
	import gbs_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  box_t         box,
	input  logic [15:0]  iou_limit,
	output status_t      stat,
	output logic         strobe,
	output result_t      result
);

	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] j_q;
	logic [MAX_BOXES-1:0] done_q, supp_q;
	logic best_v_q, pend_v_q;
	logic [AW-1:0] best_q, pend_q;
	logic [SCORE_W-1:0] best_score_q;

	logic full, wr;
	logic signed [COORD_W:0] dx, dy;
	logic signed [2*COORD_W+1:0] area_full;
	logic [BOX_W-1:0] box_rd;
	logic [AREA_W-1:0] area_rd;
	logic [SCORE_W-1:0] score_rd;
	logic [AW-1:0] box_raddr;
	logic cand;

	assign full = (cnt_q == CW'(MAX_BOXES));
	assign wr = cmd.load && !full;
	assign dx = {box.right_x[COORD_W-1], box.right_x} - {box.left_x[COORD_W-1], box.left_x};
	assign dy = {box.bottom_y[COORD_W-1], box.bottom_y} - {box.top_y[COORD_W-1], box.top_y};
	assign area_full = dx * dy;
	assign box_raddr = cmd.fetch ? best_q : j_q;
	assign cand = !done_q[j_q] && !supp_q[j_q];

	gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk(clk), .we(wr), .waddr(cnt_q[AW-1:0]),
		.wdata({box.bottom_y, box.right_x, box.top_y, box.left_x}),
		.raddr(box_raddr), .rdata(box_rd)
	);

	gbs_ram #(.WIDTH(AREA_W), .DEPTH(MAX_BOXES)) u_area_ram (
		.clk(clk), .we(wr), .waddr(cnt_q[AW-1:0]),
		.wdata(area_full[AREA_W-1:0]),
		.raddr(box_raddr), .rdata(area_rd)
	);

	gbs_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
		.clk(clk), .we(wr), .waddr(cnt_q[AW-1:0]), .wdata(box.score),
		.raddr(j_q), .rdata(score_rd)
	);

	// pivot box
	logic signed [COORD_W-1:0] pl_q, pt_q, pr_q, pb_q;
	logic signed [AREA_W-1:0] pa_q;

	// selection pipe
	logic sel_v_s1;
	logic [AW-1:0] sel_j_s1;

	// overlap pipe
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] j_s1, j_s2, j_s3, j_s4, j_s5;
	logic [COORD_W-1:0] w_s2, h_s2;
	logic signed [AREA_W-1:0] aj_s2;
	logic [2*COORD_W-1:0] inter_s3, inter_s4, inter_s5;
	logic signed [AREA_W:0] asum_s3;
	logic signed [AREA_W+1:0] uni_s4;
	logic pos_s5;
	logic [SCORE_W+AREA_W:0] prod_s5;

	logic signed [COORD_W-1:0] jl, jt, jr, jb, mxl, mxt, mnr, mnb;
	logic signed [COORD_W:0] wd, hd;
	logic hit;

	assign {jb, jr, jt, jl} = box_rd;
	assign mxl = (jl > pl_q) ? jl : pl_q;
	assign mxt = (jt > pt_q) ? jt : pt_q;
	assign mnr = (jr < pr_q) ? jr : pr_q;
	assign mnb = (jb < pb_q) ? jb : pb_q;
	assign wd = {mnr[COORD_W-1], mnr} - {mxl[COORD_W-1], mxl};
	assign hd = {mnb[COORD_W-1], mnb} - {mxt[COORD_W-1], mxt};
	assign hit = v_s5 && pos_s5 &&
		((SCORE_W+AREA_W+1)'({inter_s5, 16'd0}) > prod_s5);

	always_ff @(posedge clk) begin
		if (cmd.pivot_latch) begin
			{pb_q, pr_q, pt_q, pl_q} <= box_rd;
			pa_q <= area_rd;
		end
		sel_j_s1 <= j_q;
		j_s1 <= j_q;
		w_s2 <= wd[COORD_W] ? '0 : wd[COORD_W-1:0];
		h_s2 <= hd[COORD_W] ? '0 : hd[COORD_W-1:0];
		aj_s2 <= area_rd;
		j_s2 <= j_s1;
		inter_s3 <= w_s2 * h_s2;
		asum_s3 <= (AREA_W+1)'(pa_q) + (AREA_W+1)'(aj_s2);
		j_s3 <= j_s2;
		uni_s4 <= (AREA_W+2)'(asum_s3) - $signed({2'b00, inter_s3});
		inter_s4 <= inter_s3;
		j_s4 <= j_s3;
		pos_s5 <= (uni_s4 > 0);
		prod_s5 <= iou_limit * uni_s4[AREA_W:0];
		inter_s5 <= inter_s4;
		j_s5 <= j_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			j_q <= '0;
			done_q <= '0;
			supp_q <= '0;
			best_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			best_q <= '0;
			pend_q <= '0;
			best_score_q <= '0;
			sel_v_s1 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			strobe <= 1'b0;
			result <= '0;
		end else begin
			strobe <= (cmd.fetch && pend_v_q) || cmd.emit_last;
			if (wr) cnt_q <= cnt_q + 1'b1;
			if (cmd.scan_clr) begin
				j_q <= '0;
				best_v_q <= 1'b0;
			end else if (cmd.sel_issue || cmd.cmp_issue) begin
				j_q <= j_q + 1'b1;
			end
			sel_v_s1 <= cmd.sel_issue && cand;
			v_s1 <= cmd.cmp_issue && cand;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			// ascending scan with strict compare keeps the earlier box on ties
			if (sel_v_s1 && (!best_v_q || score_rd > best_score_q)) begin
				best_v_q <= 1'b1;
				best_q <= sel_j_s1;
				best_score_q <= score_rd;
			end
			if (hit) supp_q[j_s5] <= 1'b1;
			if (cmd.fetch) begin
				done_q[best_q] <= 1'b1;
				pend_q <= best_q;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					result <= '{kept_index: IDX_W'(pend_q), last_kept: 1'b0};
				end
			end
			if (cmd.emit_last) begin
				result <= '{kept_index: IDX_W'(pend_q), last_kept: 1'b1};
				pend_v_q <= 1'b0;
				cnt_q <= '0;
				done_q <= '0;
				supp_q <= '0;
			end
		end
	end

	assign stat.scan_last = ({1'b0, j_q} == (AW+1)'(cnt_q - 1'b1));
	assign stat.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);
	assign stat.found = best_v_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BOXES))
		else $error("box count above capacity");
	a_fetch_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> !done_q[best_q] && !supp_q[best_q])
		else $error("selected box already taken or suppressed");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_last |=> cnt_q == '0 && !pend_v_q && strobe && result.last_kept)
		else $error("set not closed after final result");

endmodule

// ===== hdl/greedy_box_suppression.sv =====
// Greedy IoU non-maximum suppression over a set of up to MAX_BOXES boxes.
// Boxes load one per cycle with start while idle. After the final box, each pick
// runs a score scan and then an overlap scan over the set; results leave one per pick.
// Reset clears the box count and flags and sets iou_limit to 29491.
// Results are one-cycle strobes; the receiver cannot stall them.
module greedy_box_suppression
	import gbs_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  box_t        box,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output result_t     result
);

	logic [15:0] iou_limit_q;
	cmd_t cmd;
	status_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_limit_q <= IOU_LIMIT_RST;
		end else if (cfg_we) begin
			iou_limit_q <= cfg_data;
		end
	end

	gbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .final_box(box.final_box),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	gbs_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .box(box), .iou_limit(iou_limit_q),
		.stat(stat), .strobe(strobe), .result(result)
	);

endmodule

// ===== tb/greedy_box_suppression_tb.sv =====
// Self-checking testbench for greedy_box_suppression: box sets go in through a queue-fed
// driver, a clocked monitor compares each kept-index strobe with a local NMS model.
// Depends on gbs_pkg and the greedy_box_suppression RTL.
module greedy_box_suppression_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gbs_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	box_t box;
	logic cfg_we;
	logic [15:0] cfg_data;
	logic strobe;
	result_t result;

	greedy_box_suppression u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .box(box),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .strobe(strobe), .result(result)
	);

	box_t request_q[$];
	result_t kept_q[$];
	int errors = 0;
	int unsigned cycles = 0;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	function automatic void add_request(box_t b);
		request_q = {request_q, b};
	endfunction

	// local model state
	logic [15:0] iou_thr;
	box_t set_boxes[MAX_BOXES_DEF];
	longint set_area[MAX_BOXES_DEF];
	int set_len;

	function automatic int smin(int a, int b); return a < b ? a : b; endfunction
	function automatic int smax(int a, int b); return a > b ? a : b; endfunction

	function automatic bit too_close(int a, int b);
		longint w, h, inter, uni;
		w = longint'(smin(set_boxes[a].right_x, set_boxes[b].right_x))
			- longint'(smax(set_boxes[a].left_x, set_boxes[b].left_x));
		h = longint'(smin(set_boxes[a].bottom_y, set_boxes[b].bottom_y))
			- longint'(smax(set_boxes[a].top_y, set_boxes[b].top_y));
		if (w < 0) w = 0;
		if (h < 0) h = 0;
		inter = w * h;
		uni = set_area[a] + set_area[b] - inter;
		if (uni <= 0) return 0;
		return inter * 65536 > longint'({48'd0, iou_thr}) * uni;
	endfunction

	task automatic predict_suppression(box_t b);
		int ord[MAX_BOXES_DEF];
		bit gone[MAX_BOXES_DEF];
		int v, m, cnt, last;
		result_t r;
		if (set_len < MAX_BOXES_DEF) begin
			set_boxes[set_len] = b;
			set_area[set_len] = (longint'(b.right_x) - longint'(b.left_x))
				* (longint'(b.bottom_y) - longint'(b.top_y));
			set_len++;
		end
		if (!b.final_box) return;
		for (int k = 0; k < set_len; k++) begin
			ord[k] = k;
			gone[k] = 0;
		end
		for (int k = 1; k < set_len; k++) begin
			v = ord[k];
			m = k;
			while (m > 0 && set_boxes[ord[m-1]].score < set_boxes[v].score) begin
				ord[m] = ord[m-1];
				m--;
			end
			ord[m] = v;
		end
		cnt = 0;
		for (int k = 0; k < set_len; k++) begin
			if (gone[ord[k]]) continue;
			r.kept_index = ord[k][5:0];
			r.last_kept = 0;
			kept_q = {kept_q, r};
			cnt++;
			for (int j = k + 1; j < set_len; j++)
				if (!gone[ord[j]] && too_close(ord[k], ord[j])) gone[ord[j]] = 1;
		end
		last = kept_q.size() - 1;
		kept_q[last].last_kept = 1;
		set_len = 0;
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver: random gap after each accepted request
	int gap = 0;
	always @(posedge clk) begin
		if (start && !busy) begin
			start <= 0;
			gap <= $urandom_range(0, 10);
		end else if (!start && !busy && request_q.size() > 0 && arst_n) begin
			if (gap > 0) gap <= gap - 1;
			else begin
				box <= request_q[0];
				predict_suppression(request_q.pop_front());
				start <= 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && strobe) begin
			if (kept_q.size() == 0) begin
				$display("%0t unexpected result idx=%0d last=%0b", $realtime,
					result.kept_index, result.last_kept);
				errors++;
			end else begin
				if (result !== kept_q[0])
					$display("%0t mismatch expected idx=%0d last=%0b actual idx=%0d last=%0b",
						$realtime, kept_q[0].kept_index, kept_q[0].last_kept,
						result.kept_index, result.last_kept);
				if (result !== kept_q[0]) errors++;
				void'(kept_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic box_t rand_box(bit fin, int spread);
		box_t b;
		int cx, cy;
		cx = $urandom_range(0, 2000) - 1000;
		cy = $urandom_range(0, 2000) - 1000;
		b.left_x = 16'(cx);
		b.top_y = 16'(cy);
		b.right_x = 16'(cx + $urandom_range(0, spread));
		b.bottom_y = 16'(cy + $urandom_range(0, spread));
		b.score = 16'($urandom_range(0, 7) * 8000 + $urandom_range(0, 3));
		b.final_box = fin;
		return b;
	endfunction

	function automatic box_t mk(int x1, int y1, int x2, int y2, int s, bit fin);
		box_t b;
		b.left_x = 16'(x1); b.top_y = 16'(y1); b.right_x = 16'(x2); b.bottom_y = 16'(y2);
		b.score = 16'(s); b.final_box = fin;
		return b;
	endfunction

	task automatic drain_then_config(logic [15:0] thr);
		while (request_q.size() > 0 || kept_q.size() > 0 || start || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we <= 0;
		iou_thr = thr;
		@(posedge clk);
	endtask

	task automatic random_set(int n, int spread);
		box_t b;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) b = box_t'({$urandom, $urandom, $urandom});
			else b = rand_box(0, spread);
			b.final_box = (k == n - 1);
			add_request(b);
		end
	endtask

	initial begin
		int n;
		logic [15:0] thr;
		arst_n = 0;
		start = 0;
		box = '0;
		cfg_we = 0;
		cfg_data = '0;
		iou_thr = IOU_LIMIT_RST;
		set_len = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, single box, ties, inverted, zero area, full overlap
		add_request(mk(-32768, -32768, 32767, 32767, 65535, 0));
		add_request(mk(-32768, -32768, 32767, 32767, 0, 1));
		add_request(mk(5, 5, 5, 5, 100, 1));
		add_request(mk(0, 0, 100, 100, 500, 0));
		add_request(mk(0, 0, 100, 100, 500, 0));
		add_request(mk(50, 50, 150, 150, 500, 0));
		add_request(mk(100, 100, 0, 0, 900, 0));
		add_request(mk(0, 0, 100, 0, 800, 0));
		add_request(mk(32767, 32767, -32768, -32768, 700, 1));
		add_request(mk(0, 0, 100, 100, 1000, 0));
		add_request(mk(10, 0, 110, 100, 999, 1));
		drain_then_config(16'd0);
		add_request(mk(0, 0, 100, 100, 1000, 0));
		add_request(mk(99, 99, 200, 200, 999, 0));
		add_request(mk(300, 300, 400, 400, 998, 1));
		drain_then_config(16'hFFFF);
		add_request(mk(0, 0, 100, 100, 1000, 0));
		add_request(mk(0, 0, 100, 100, 1000, 1));
		// overflow: 66 boxes into one set, last two dropped
		drain_then_config(IOU_LIMIT_RST);
		random_set(66, 300);
		// random phases with various thresholds
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: thr = 16'd0;
				1: thr = 16'hFFFF;
				default: thr = 16'($urandom);
			endcase
			drain_then_config(thr);
			for (int s = 0; s < 4; s++) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
				random_set(n, $urandom_range(0, 1) ? 200 : 2000);
			end
		end
		while (request_q.size() > 0 || kept_q.size() > 0 || start || busy) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && kept_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hdl/gbs_pkg.sv
hdl/gbs_ram.sv
hdl/gbs_ctrl.sv
hdl/gbs_dp.sv
hdl/greedy_box_suppression.sv
tb/greedy_box_suppression_tb.sv
